// ===== hdl/xcfd_pkg.sv =====
`default_nettype none
package xcfd_pkg;

	localparam int BYTE_W = 8;
	localparam int HLEN_W = 4;
	localparam int FLEN_W = 4;
	localparam int PLEN_W = 12;
	localparam int CNT_W = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
	localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER_LEN = 2'd0,
		REG_FOOTER_LEN = 2'd1,
		REG_PAYLOAD_LEN = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_FOOTER = 2'd2,
		ST_INCOMPLETE = 2'd3
	} frame_status_t;

	typedef struct packed {
		logic [HLEN_W-1:0] header_need;
		logic [FLEN_W-1:0] footer_len;
		logic [PLEN_W-1:0] payload_need;
	} cfg_t;

	typedef struct packed {
		logic is_status;
		logic [BYTE_W-1:0] out_byte;
		frame_status_t frame_status;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/xcfd_if.sv =====
`default_nettype none
interface xcfd_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

interface xcfd_out_if;
	logic valid;
	logic ready;
	logic is_status;
	logic [7:0] out_byte;
	logic [1:0] frame_status;

	modport source(output valid, output is_status, output out_byte, output frame_status,
		input ready);
	modport sink(input valid, input is_status, input out_byte, input frame_status,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/xcfd_cfg.sv =====
`default_nettype none
module xcfd_cfg
	import xcfd_pkg::*;
#(
	parameter int MAX_PAYLOAD = 4095
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t cfg
);

	localparam int PLEN_MAX = (1 << PLEN_W) - 1;
	localparam logic [PLEN_W-1:0] PLEN_CLAMP =
		PLEN_W'((MAX_PAYLOAD > PLEN_MAX) ? PLEN_MAX : MAX_PAYLOAD);

	logic [HLEN_W-1:0] header_len_q;
	logic [FLEN_W-1:0] footer_len_q;
	logic [PLEN_W-1:0] payload_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_len_q <= HLEN_W'(2);
			footer_len_q <= FLEN_W'(2);
			payload_len_q <= PLEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER_LEN: header_len_q <= cfg_wdata[HLEN_W-1:0];
				REG_FOOTER_LEN: footer_len_q <= cfg_wdata[FLEN_W-1:0];
				REG_PAYLOAD_LEN: payload_len_q <= cfg_wdata[PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.header_need = (header_len_q == '0) ? HLEN_W'(1) : header_len_q;
		cfg.footer_len = footer_len_q;
		if (payload_len_q == '0) begin
			cfg.payload_need = PLEN_W'(1);
		end else if (payload_len_q > PLEN_CLAMP) begin
			cfg.payload_need = PLEN_CLAMP;
		end else begin
			cfg.payload_need = payload_len_q;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/xcfd_core.sv =====
`default_nettype none
module xcfd_core
	import xcfd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input cfg_t cfg,
	xcfd_in_if.sink rx,
	output logic res_valid,
	output res_t res,
	input wire logic res_free
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_PAYLOAD,
		PH_CHECK,
		PH_FOOTER
	} phase_t;

	logic valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	phase_t phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic [BYTE_W-1:0] xor_q, xor_d;
	logic good_q, good_d;
	logic prod;
	logic adv;

	assign cnt_inc = cnt_q + CNT_W'(1);
	assign adv = valid_s1 && (!prod || res_free);
	assign rx.ready = !valid_s1 || adv;
	assign res_valid = valid_s1 && prod && res_free;

	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		xor_d = xor_q;
		good_d = good_q;
		prod = 1'b0;
		res = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == HDR_BYTE) begin
					if (cnt_inc >= CNT_W'(cfg.header_need)) begin
						phase_d = PH_PAYLOAD;
						cnt_d = '0;
						xor_d = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end else begin
					cnt_d = '0;
				end
			end
			PH_PAYLOAD: begin
				xor_d = xor_q ^ byte_s1;
				prod = 1'b1;
				res.out_byte = byte_s1;
				if (cnt_inc >= CNT_W'(cfg.payload_need)) begin
					phase_d = PH_CHECK;
					cnt_d = '0;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_CHECK: begin
				if (byte_s1 != xor_q) begin
					prod = 1'b1;
					res.is_status = 1'b1;
					res.frame_status = (byte_s1 == ZERO_BYTE) ? ST_INCOMPLETE : ST_CHECKSUM;
				end else if (cfg.footer_len == '0) begin
					prod = 1'b1;
					res.is_status = 1'b1;
					res.frame_status = ST_OK;
				end else begin
					phase_d = PH_FOOTER;
					cnt_d = '0;
					good_d = 1'b1;
				end
			end
			PH_FOOTER: begin
				good_d = good_q && (byte_s1 == ZERO_BYTE);
				cnt_d = cnt_inc;
				if (cnt_inc >= CNT_W'(cfg.footer_len)) begin
					prod = 1'b1;
					res.is_status = 1'b1;
					res.frame_status = good_d ? ST_OK : ST_FOOTER;
				end
			end
			default: ;
		endcase
		// every status sends the block back to hunting
		if (res.is_status) begin
			phase_d = PH_HUNT;
			cnt_d = '0;
			xor_d = '0;
			good_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q <= '0;
			xor_q <= '0;
			good_q <= 1'b1;
		end else if (adv) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			xor_q <= xor_d;
			good_q <= good_d;
		end
	end

	a_data_from_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.is_status) |-> (phase_q == PH_PAYLOAD))
		else $error("data result outside payload phase");

	a_status_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.is_status) |=> (phase_q == PH_HUNT && xor_q == '0))
		else $error("status did not return to hunting");

	a_hunt_xor_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT) |-> (xor_q == '0 && good_q))
		else $error("stale checksum state while hunting");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input stage lost a request");

endmodule
`default_nettype wire

// ===== hdl/xcfd_out.sv =====
`default_nettype none
module xcfd_out
	import xcfd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input res_t res,
	output logic res_free,
	xcfd_out_if.source tx
);

	logic valid_q;
	res_t res_q;

	assign res_free = !valid_q || tx.ready;
	assign tx.valid = valid_q;
	assign tx.is_status = res_q.is_status;
	assign tx.out_byte = res_q.out_byte;
	assign tx.frame_status = res_q.frame_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/xor_checked_frame_deframer_top.sv =====
// channel | role   | payload                                 | handshake
// rx      | sink   | in_byte[7:0]                            | valid/ready
// res     | source | is_status, out_byte[7:0], frame_status  | valid/ready
// cfg     | write  | cfg_index[1:0], cfg_wdata[11:0]         | cfg_we
//
// one byte per cycle sustained while no result is stalled
// the byte goes through an input register, a registered state update and the result register
// arst_n clears all control state; length registers reset to header 2, footer 2, payload 1
// a stalled result holds the output register; the input register keeps taking bytes that
// produce no result and one more byte while a result waits
`default_nettype none
module xor_checked_frame_deframer_top
	import xcfd_pkg::*;
#(
	parameter int MAX_PAYLOAD = 4095
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_wdata,
	xcfd_in_if.sink rx,
	xcfd_out_if.source res
);

	cfg_t cfg;
	logic core_valid;
	res_t core_res;
	logic core_free;

	xcfd_cfg #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	xcfd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.rx(rx),
		.res_valid(core_valid),
		.res(core_res),
		.res_free(core_free)
	);

	xcfd_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.res_valid(core_valid),
		.res(core_res),
		.res_free(core_free),
		.tx(res)
	);

endmodule
`default_nettype wire
